>>> rtl/core/rrbf_pkg.sv
package rrbf_pkg;

    localparam int ADDR_W = 64;
    localparam int TIME_W = 32;

    localparam logic [2:0] CFG_RATE_LIMIT = 3'd0;
    localparam logic [2:0] CFG_VIOL_THR   = 3'd1;
    localparam logic [2:0] CFG_BLOCK_DUR  = 3'd2;
    localparam logic [2:0] CFG_DUP_WIN    = 3'd3;
    localparam logic [2:0] CFG_AUTO_EN    = 3'd4;

    localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
    localparam logic [1:0] VERDICT_REPLAY  = 2'd1;
    localparam logic [1:0] VERDICT_BLOCKED = 2'd2;

    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_UNBLOCK = 1'b1;

    typedef struct packed {
        logic [7:0]  rate_limit;
        logic [15:0] viol_thr;
        logic [31:0] block_dur;
        logic [15:0] dup_win;
        logic        auto_en;
    } t_cfg;

endpackage

>>> rtl/core/rrbf_cfg_regs.sv
module rrbf_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output rrbf_pkg::t_cfg      o_cfg
);
    import rrbf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_limit <= 8'd3;
            r_cfg.viol_thr   <= 16'd5;
            r_cfg.block_dur  <= 32'd600;
            r_cfg.dup_win    <= 16'd5;
            r_cfg.auto_en    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE_LIMIT: r_cfg.rate_limit <= i_cfg_data[7:0];
                CFG_VIOL_THR:   r_cfg.viol_thr   <= i_cfg_data[15:0];
                CFG_BLOCK_DUR:  r_cfg.block_dur  <= i_cfg_data;
                CFG_DUP_WIN:    r_cfg.dup_win    <= i_cfg_data[15:0];
                CFG_AUTO_EN:    r_cfg.auto_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> rtl/core/replay_rate_blacklist_filter.sv
// Replay rate limiter with per-sender blacklist.
// Input: raise start while busy is low with the request fields; the item
// is taken at that edge. Result: o_done high for one cycle with the verdict
// and flags. The receiver cannot stall; results are never held.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data, write while idle.
// Sequence: an observe item scans the node table one entry a cycle, then
// the blacklist, then updates its counters; each violation that reaches
// the threshold with auto-blocking enabled adds one more blacklist scan, at
// most two per item. An unblock item scans only the blacklist. o_done
// rises in the cycle busy falls.
// One item at a time, the shared entry comparator setting the pace.
// Reset: both tables clear at once (per-entry flip-flops) and the registers
// take their defaults; the block is ready in the cycle after reset.
module replay_rate_blacklist_filter #(
    parameter int NODE_ENTRIES  = 10,
    parameter int BLOCK_ENTRIES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [63:0] i_sender_hi,
    input  logic [63:0] i_sender_lo,
    input  logic [15:0] i_rank,
    input  logic [7:0]  i_version,
    input  logic [31:0] i_now_seconds,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_verdict,
    output logic        o_rate_violation,
    output logic        o_duplicate_violation,
    output logic        o_newly_blocked,
    output logic        o_unblock_found
);
    import rrbf_pkg::*;

    localparam int NW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
    localparam int BW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int NC = $clog2(NODE_ENTRIES + 1);
    localparam int BC = $clog2(BLOCK_ENTRIES + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_NSCAN = 9'b000000010,
        S_CLAIM = 9'b000000100,
        S_BSCAN = 9'b000001000,
        S_RATE  = 9'b000010000,
        S_DUP   = 9'b000100000,
        S_VIOL  = 9'b001000000,
        S_ISCAN = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_cfg cfg;
    rrbf_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    logic [63:0] r_n_hi [NODE_ENTRIES];
    logic [63:0] r_n_lo [NODE_ENTRIES];
    logic [31:0] r_n_seen [NODE_ENTRIES];
    logic [15:0] r_n_rank [NODE_ENTRIES];
    logic [7:0]  r_n_ver [NODE_ENTRIES];
    logic [7:0]  r_n_cnt [NODE_ENTRIES];
    logic [31:0] r_n_sec [NODE_ENTRIES];
    logic [31:0] r_n_viol [NODE_ENTRIES];
    logic [63:0] r_b_hi [BLOCK_ENTRIES];
    logic [63:0] r_b_lo [BLOCK_ENTRIES];
    logic [31:0] r_b_time [BLOCK_ENTRIES];
    logic [BLOCK_ENTRIES-1:0] r_b_act;

    t_state      r_state;
    logic [NC-1:0] r_ni;
    logic [BC-1:0] r_bi;
    logic [NW-1:0] r_node, r_pick;
    logic [BW-1:0] r_free, r_old;
    logic        r_have_free;
    logic [31:0] r_old_time;
    logic        r_req;
    logic [63:0] r_hi, r_lo;
    logic [15:0] r_rank;
    logic [7:0]  r_ver;
    logic [31:0] r_now;
    logic        r_rate_v, r_dup_v, r_newly, r_found, r_blocked, r_viol2;
    logic        r_done;
    logic [1:0]  r_verdict;

    // shared entry comparator
    logic [NW-1:0] ni;
    logic [BW-1:0] bi;
    logic          n_match, b_match;
    assign ni = r_ni[NW-1:0];
    assign bi = r_bi[BW-1:0];
    assign n_match = (r_n_hi[ni] == r_hi) && (r_n_lo[ni] == r_lo);
    assign b_match = r_b_act[bi] && (r_b_hi[bi] == r_hi) && (r_b_lo[bi] == r_lo);

    logic [31:0] viol_inc;
    assign viol_inc = (r_n_viol[r_node] != 32'hFFFFFFFF) ?
                      r_n_viol[r_node] + 32'd1 : r_n_viol[r_node];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_state <= S_IDLE;
            r_b_act <= '0;
            for (int k = 0; k < NODE_ENTRIES; k++) begin
                r_n_hi[k] <= '0; r_n_lo[k] <= '0; r_n_seen[k] <= '0;
                r_n_rank[k] <= '0; r_n_ver[k] <= '0; r_n_cnt[k] <= '0;
                r_n_sec[k] <= '0; r_n_viol[k] <= '0;
            end
            for (int k = 0; k < BLOCK_ENTRIES; k++) begin
                r_b_hi[k] <= '0; r_b_lo[k] <= '0; r_b_time[k] <= '0;
            end
        end else begin
            r_done <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: if (start) begin
                    r_req <= i_req_type; r_hi <= i_sender_hi; r_lo <= i_sender_lo;
                    r_rank <= i_rank; r_ver <= i_version; r_now <= i_now_seconds;
                    r_rate_v <= 1'b0; r_dup_v <= 1'b0; r_newly <= 1'b0;
                    r_found <= 1'b0; r_blocked <= 1'b0; r_viol2 <= 1'b0;
                    r_ni <= '0; r_bi <= '0; r_pick <= '0;
                    r_state <= (i_req_type == REQ_UNBLOCK) ? S_BSCAN : S_NSCAN;
                end
                S_NSCAN: begin
                    if (n_match) begin
                        r_node <= ni;
                        r_state <= S_BSCAN;
                    end else begin
                        if (r_n_seen[ni] < r_n_seen[r_pick]) r_pick <= ni;
                        if (r_ni == NC'(NODE_ENTRIES - 1)) r_state <= S_CLAIM;
                        r_ni <= r_ni + NC'(1);
                    end
                end
                S_CLAIM: begin
                    r_n_hi[r_pick] <= r_hi; r_n_lo[r_pick] <= r_lo;
                    r_n_seen[r_pick] <= '0; r_n_rank[r_pick] <= '0;
                    r_n_ver[r_pick] <= '0; r_n_cnt[r_pick] <= '0;
                    r_n_sec[r_pick] <= '0; r_n_viol[r_pick] <= '0;
                    r_node <= r_pick;
                    r_state <= S_BSCAN;
                end
                S_BSCAN: begin
                    if (b_match) begin
                        if (r_req == REQ_UNBLOCK) begin
                            r_b_act[bi] <= 1'b0;
                            r_found <= 1'b1;
                            r_state <= S_DONE;
                        end else if (32'(r_now - r_b_time[bi]) > cfg.block_dur) begin
                            r_b_act[bi] <= 1'b0;
                            r_state <= S_RATE;
                        end else begin
                            r_blocked <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (r_bi == BC'(BLOCK_ENTRIES - 1))
                            r_state <= (r_req == REQ_UNBLOCK) ? S_DONE : S_RATE;
                        r_bi <= r_bi + BC'(1);
                    end
                end
                S_RATE: begin
                    // count this second's messages, saturating
                    logic [7:0] cnt;
                    cnt = (r_n_sec[r_node] != r_now) ? 8'd0 : r_n_cnt[r_node];
                    if (cnt != 8'hFF) cnt = cnt + 8'd1;
                    r_n_cnt[r_node] <= cnt;
                    r_n_sec[r_node] <= r_now;
                    r_rate_v <= (cnt > cfg.rate_limit);
                    r_state <= (cnt > cfg.rate_limit) ? S_VIOL : S_DUP;
                    r_viol2 <= 1'b0;
                end
                S_DUP: begin
                    r_n_seen[r_node] <= r_now;
                    r_n_rank[r_node] <= r_rank;
                    r_n_ver[r_node] <= r_ver;
                    if (r_n_seen[r_node] != 32'd0 && r_n_rank[r_node] == r_rank &&
                        r_n_ver[r_node] == r_ver &&
                        32'(r_now - r_n_seen[r_node]) < {16'd0, cfg.dup_win}) begin
                        r_dup_v <= 1'b1;
                        r_viol2 <= 1'b1;
                        r_state <= S_VIOL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_VIOL: begin
                    r_n_viol[r_node] <= viol_inc;
                    r_bi <= '0; r_have_free <= 1'b0; r_old <= '0;
                    r_old_time <= 32'hFFFFFFFF;
                    if (cfg.auto_en && viol_inc >= {16'd0, cfg.viol_thr})
                        r_state <= S_ISCAN;
                    else
                        r_state <= r_viol2 ? S_DONE : S_DUP;
                end
                S_ISCAN: begin
                    if (b_match) begin
                        r_b_time[bi] <= r_now;
                        r_state <= r_viol2 ? S_DONE : S_DUP;
                    end else begin
                        logic [BW-1:0] slot;
                        logic          hf;
                        hf = r_have_free;
                        slot = r_free;
                        if (!r_b_act[bi] && !hf) begin
                            hf = 1'b1; slot = bi;
                        end
                        r_have_free <= hf; r_free <= slot;
                        if (r_b_time[bi] < r_old_time) begin
                            r_old_time <= r_b_time[bi];
                            r_old <= bi;
                        end
                        if (r_bi == BC'(BLOCK_ENTRIES - 1)) begin
                            logic [BW-1:0] w;
                            w = hf ? slot :
                                ((r_b_time[bi] < r_old_time) ? bi : r_old);
                            r_b_hi[w] <= r_hi; r_b_lo[w] <= r_lo;
                            r_b_time[w] <= r_now; r_b_act[w] <= 1'b1;
                            r_newly <= 1'b1;
                            r_state <= r_viol2 ? S_DONE : S_DUP;
                        end
                        r_bi <= r_bi + BC'(1);
                    end
                end
                S_DONE: begin
                    r_verdict <= (r_req == REQ_UNBLOCK) ? VERDICT_ACCEPT :
                                 r_blocked ? VERDICT_BLOCKED :
                                 (r_rate_v || r_dup_v) ? VERDICT_REPLAY : VERDICT_ACCEPT;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_verdict = r_verdict;
    assign o_rate_violation = r_done & r_rate_v;
    assign o_duplicate_violation = r_done & r_dup_v;
    assign o_newly_blocked = r_done & r_newly;
    assign o_unblock_found = r_done & r_found;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    a_blocked_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_verdict == VERDICT_BLOCKED) |-> !o_rate_violation &&
        !o_duplicate_violation && !o_newly_blocked) else $error("blocked flags");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule
